// File: hdl/yiq_pkg.sv
// ============================================================================
// yiq_pkg
// Shared types, coefficients and codes for the YIQ luma adjust pixel block.
// ============================================================================
package yiq_pkg;

    // Signed Q8.8 luma and chroma triple carried between front and back.
    typedef struct packed {
        logic signed [16:0] y;
        logic signed [16:0] i;
        logic signed [16:0] q;
    } yiq_t;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_GAIN      = 2'd2;

    // Luma adjust mode codes.
    localparam logic [2:0] MODE_PASS      = 3'd0;
    localparam logic [2:0] MODE_NEGATE    = 3'd1;
    localparam logic [2:0] MODE_BINARY    = 3'd2;
    localparam logic [2:0] MODE_ABOVE_MAX = 3'd3;
    localparam logic [2:0] MODE_TRUNCATE  = 3'd4;
    localparam logic [2:0] MODE_GAIN      = 3'd5;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  threshold;
        logic [15:0] gain;
    } luma_cfg_t;

    // Full-scale luma, 255.0 in Q8.8.
    localparam logic signed [16:0] Y_MAX = 17'sd65280;

    // Forward matrix, Q12.
    localparam logic signed [13:0] FWD_YR = 14'sd1225;
    localparam logic signed [13:0] FWD_YG = 14'sd2404;
    localparam logic signed [13:0] FWD_YB = 14'sd467;
    localparam logic signed [13:0] FWD_IR = 14'sd2441;
    localparam logic signed [13:0] FWD_IG = -14'sd1122;
    localparam logic signed [13:0] FWD_IB = -14'sd1319;
    localparam logic signed [13:0] FWD_QR = 14'sd864;
    localparam logic signed [13:0] FWD_QG = -14'sd2142;
    localparam logic signed [13:0] FWD_QB = 14'sd1278;

    // Inverse matrix, Q12.
    localparam logic signed [13:0] INV_RY = 14'sd4096;
    localparam logic signed [13:0] INV_RI = 14'sd3916;
    localparam logic signed [13:0] INV_RQ = 14'sd2544;
    localparam logic signed [13:0] INV_GY = 14'sd4096;
    localparam logic signed [13:0] INV_GI = -14'sd1114;
    localparam logic signed [13:0] INV_GQ = -14'sd2650;
    localparam logic signed [13:0] INV_BY = 14'sd4096;
    localparam logic signed [13:0] INV_BI = -14'sd4530;
    localparam logic signed [13:0] INV_BQ = 14'sd6975;

    // One row of the forward matrix, rounded from Q12 to Q8.
    function automatic logic signed [16:0] fwd_row(
        input logic signed [13:0] c0,
        input logic signed [13:0] c1,
        input logic signed [13:0] c2,
        input logic [7:0]         r,
        input logic [7:0]         g,
        input logic [7:0]         b
    );
        logic signed [21:0] rr;
        logic signed [21:0] gg;
        logic signed [21:0] bb;
        logic signed [21:0] sum;
        logic signed [21:0] rounded;
        rr      = $signed({14'd0, r});
        gg      = $signed({14'd0, g});
        bb      = $signed({14'd0, b});
        sum     = 22'(c0) * rr + 22'(c1) * gg + 22'(c2) * bb;
        rounded = (sum + 22'sd8) >>> 4;
        return 17'(rounded);
    endfunction

    // One row of the inverse matrix, Q20 result.
    function automatic logic signed [31:0] inv_row(
        input logic signed [13:0] c0,
        input logic signed [13:0] c1,
        input logic signed [13:0] c2,
        input logic signed [16:0] y,
        input logic signed [16:0] i,
        input logic signed [16:0] q
    );
        return 32'(c0) * 32'(y) + 32'(c1) * 32'(i) + 32'(c2) * 32'(q);
    endfunction

endpackage

// File: hdl/yiq_front.sv
// ============================================================================
// yiq_front
// Accepts RGB pixels and converts them to registered Q8.8 YIQ values.
// ============================================================================
module yiq_front
    import yiq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output yiq_t       out_yiq
);

    logic valid_reg;
    logic valid_next;
    yiq_t yiq_reg;
    yiq_t yiq_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        yiq_next.y = fwd_row(FWD_YR, FWD_YG, FWD_YB, red, green, blue);
        yiq_next.i = fwd_row(FWD_IR, FWD_IG, FWD_IB, red, green, blue);
        yiq_next.q = fwd_row(FWD_QR, FWD_QG, FWD_QB, red, green, blue);
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            yiq_reg <= yiq_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_yiq   = yiq_reg;

endmodule

// File: hdl/yiq_queue.sv
// ============================================================================
// yiq_queue
// Short first-in first-out queue of YIQ values between front and back.
// ============================================================================
module yiq_queue
    import yiq_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  yiq_t in_yiq,
    output logic out_valid,
    input  logic out_ready,
    output yiq_t out_yiq
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    yiq_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_yiq   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_yiq;
        end
    end

endmodule

// File: hdl/yiq_back.sv
// ============================================================================
// yiq_back
// Adjusts luma by mode, converts back to RGB, then rounds and clamps.
// ============================================================================
module yiq_back
    import yiq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  luma_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  yiq_t       in_yiq,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic               advance;
    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    yiq_t               a_yiq_reg;
    logic [31:0]        a_prod_reg;
    logic [31:0]        a_prod_next;
    logic signed [31:0] b_r_reg;
    logic signed [31:0] b_g_reg;
    logic signed [31:0] b_b_reg;
    logic signed [31:0] b_r_next;
    logic signed [31:0] b_g_next;
    logic signed [31:0] b_b_next;
    logic signed [16:0] y_adj;
    logic signed [16:0] thr_q8;
    logic [24:0]        gain_y;
    logic [7:0]         c_r_reg;
    logic [7:0]         c_g_reg;
    logic [7:0]         c_b_reg;

    function automatic logic [7:0] round_clamp(input logic signed [31:0] acc);
        logic signed [31:0] v;
        v = (acc + 32'sd524288) >>> 20;
        if (v < 0)
        begin
            return 8'd0;
        end
        else if (v > 32'sd255)
        begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

    assign advance  = !c_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        a_prod_next = 32'(in_yiq.y[15:0]) * 32'(cfg.gain);
    end

    always_comb
    begin
        thr_q8 = $signed({1'b0, cfg.threshold, 8'd0});
        gain_y = 25'((33'(a_prod_reg) + 33'd128) >> 8);
        unique case (cfg.mode)
            MODE_NEGATE:
                y_adj = Y_MAX - a_yiq_reg.y;
            MODE_BINARY:
                y_adj = (a_yiq_reg.y > thr_q8) ? Y_MAX : 17'sd0;
            MODE_ABOVE_MAX:
                y_adj = (a_yiq_reg.y > thr_q8) ? Y_MAX : a_yiq_reg.y;
            MODE_TRUNCATE:
                y_adj = (a_yiq_reg.y > thr_q8) ? thr_q8 : a_yiq_reg.y;
            MODE_GAIN:
                y_adj = (gain_y > 25'(Y_MAX)) ? Y_MAX : $signed({1'b0, gain_y[15:0]});
            default:
                y_adj = a_yiq_reg.y;
        endcase
        b_r_next = inv_row(INV_RY, INV_RI, INV_RQ, y_adj, a_yiq_reg.i, a_yiq_reg.q);
        b_g_next = inv_row(INV_GY, INV_GI, INV_GQ, y_adj, a_yiq_reg.i, a_yiq_reg.q);
        b_b_next = inv_row(INV_BY, INV_BI, INV_BQ, y_adj, a_yiq_reg.i, a_yiq_reg.q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_yiq_reg  <= in_yiq;
            a_prod_reg <= a_prod_next;
            b_r_reg    <= b_r_next;
            b_g_reg    <= b_g_next;
            b_b_reg    <= b_b_next;
            c_r_reg    <= round_clamp(b_r_reg);
            c_g_reg    <= round_clamp(b_g_reg);
            c_b_reg    <= round_clamp(b_b_reg);
        end
    end

    assign out_valid = c_valid_reg;
    assign red       = c_r_reg;
    assign green     = c_g_reg;
    assign blue      = c_b_reg;

endmodule

// File: hdl/yiq_luma_adjust_pixel.sv
// ============================================================================
// yiq_luma_adjust_pixel
// RGB pixel stream converted to YIQ, luma adjusted by mode, converted back.
// ============================================================================
// The block accepts one RGB pixel per clock cycle and returns one adjusted
// pixel per clock cycle while the output side is ready. A pixel passes from
// its input transaction to its output through the forward conversion
// register, the queue, and the back-end gain product, inverse conversion,
// and round and clamp stages. The queue of QUEUE_DEPTH entries lets the
// input keep taking pixels for a while when the output stalls.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it while no pixel is in flight. The block does not enforce this.
module yiq_luma_adjust_pixel
    import yiq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue [23:16], green [15:8], red [7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blue [23:16], green [15:8], red [7:0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    luma_cfg_t cfg_reg;
    luma_cfg_t cfg_next;
    logic      f_valid;
    logic      f_ready;
    yiq_t      f_yiq;
    logic      q_valid;
    logic      q_ready;
    yiq_t      q_yiq;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_data[2:0];
                CFG_THRESHOLD: cfg_next.threshold = cfg_data[7:0];
                CFG_GAIN:      cfg_next.gain      = cfg_data;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_PASS;
            cfg_reg.threshold <= 8'd128;
            cfg_reg.gain      <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    yiq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_yiq   (f_yiq)
    );

    yiq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_yiq    (f_yiq),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_yiq   (q_yiq)
    );

    yiq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_yiq    (q_yiq),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (m_tdata[7:0]),
        .green     (m_tdata[15:8]),
        .blue      (m_tdata[23:16])
    );

endmodule
